// File: hdl/are_pkg.sv
// Package for the ARP resolution engine: word types, action, mode, kind and op codes,
// configuration register indexes. No dependencies.
`timescale 1ns / 1ps
package are_pkg;

  localparam logic [2:0] ACT_NONE    = 3'd0;
  localparam logic [2:0] ACT_SEND    = 3'd1;
  localparam logic [2:0] ACT_REQUEST = 3'd2;
  localparam logic [2:0] ACT_REPLY   = 3'd3;
  localparam logic [2:0] ACT_RELEASE = 3'd4;

  localparam logic [1:0] MODE_ALIVE = 2'd0;
  localparam logic [1:0] MODE_WAIT  = 2'd1;
  localparam logic [1:0] MODE_DEAD  = 2'd2;

  localparam logic [1:0] KIND_TICK   = 2'd0;
  localparam logic [1:0] KIND_LOOKUP = 2'd1;
  localparam logic [1:0] KIND_ARP    = 2'd2;
  localparam logic [1:0] KIND_FLUSH  = 2'd3;

  localparam logic [1:0] OP_REQUEST = 2'd1;
  localparam logic [1:0] OP_REPLY   = 2'd2;

  localparam logic [2:0] REG_OWN_IP  = 3'd0;
  localparam logic [2:0] REG_OWN_MAC = 3'd1;
  localparam logic [2:0] REG_ALIVE   = 3'd2;
  localparam logic [2:0] REG_DEAD    = 3'd3;
  localparam logic [2:0] REG_WAIT    = 3'd4;

  localparam logic [47:0] MAC_BCAST = 48'hFFFF_FFFF_FFFF;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] target_ip;
    logic [15:0] packet_handle;
    logic [1:0]  arp_op;
    logic [31:0] sender_ip;
    logic [47:0] sender_mac;
    logic [47:0] target_mac;
  } in_word_t;

  typedef struct packed {
    logic [2:0]  action;
    logic [31:0] out_ip;
    logic [47:0] out_mac;
    logic [15:0] out_handle;
    logic        dropped_valid;
    logic [15:0] dropped_handle;
  } out_word_t;

  typedef struct packed {
    logic [31:0] own_ip;
    logic [47:0] own_mac;
    logic [31:0] alive_timeout;
    logic [31:0] dead_timeout;
    logic [31:0] wait_timeout;
  } cfg_t;

endpackage

// File: hdl/are_cfg.sv
// APB register file of the ARP resolution engine.
// Depends on are_pkg.
`timescale 1ns / 1ps
module are_cfg (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [5:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready,
  output are_pkg::cfg_t cfg
);
  logic       wr;
  logic [2:0] idx;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;
  assign idx    = paddr[5:3];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.own_ip        <= '0;
      cfg.own_mac       <= '0;
      cfg.alive_timeout <= 32'd1200;
      cfg.dead_timeout  <= 32'd1000;
      cfg.wait_timeout  <= 32'd10;
    end else if (wr) begin
      case (idx)
        are_pkg::REG_OWN_IP:  cfg.own_ip        <= pwdata[31:0];
        are_pkg::REG_OWN_MAC: cfg.own_mac       <= pwdata[47:0];
        are_pkg::REG_ALIVE:   cfg.alive_timeout <= pwdata[31:0];
        are_pkg::REG_DEAD:    cfg.dead_timeout  <= pwdata[31:0];
        are_pkg::REG_WAIT:    cfg.wait_timeout  <= pwdata[31:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (idx)
      are_pkg::REG_OWN_IP:  prdata = {32'd0, cfg.own_ip};
      are_pkg::REG_OWN_MAC: prdata = {16'd0, cfg.own_mac};
      are_pkg::REG_ALIVE:   prdata = {32'd0, cfg.alive_timeout};
      are_pkg::REG_DEAD:    prdata = {32'd0, cfg.dead_timeout};
      are_pkg::REG_WAIT:    prdata = {32'd0, cfg.wait_timeout};
      default:              prdata = '0;
    endcase
  end
endmodule

// File: hdl/arp_resolution_engine.sv
// ARP resolution engine: a sequencer walks an entry table in memory with one read and one write port.
// Depends on are_pkg and are_cfg.
// Flow: a tick or flush is applied on acceptance and goes straight to the output
// step; a lookup or ARP header passes through SCAN, LAST, DEC and OUT, where SCAN
// walks the entry memory sequentially, one read a cycle, LAST checks the final
// entry and DEC decides and writes the table. One word is worked on at a time;
// the next is accepted while the result waits in the output register. A finished
// word whose result cannot enter the output register waits in the output step
// until it does.
`timescale 1ns / 1ps
module arp_resolution_engine #(
  parameter int TABLE_ENTRIES = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  are_pkg::in_word_t    in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output are_pkg::out_word_t   out_data,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [5:0]           paddr,
  input  logic [63:0]          pwdata,
  output logic [63:0]          prdata,
  output logic                 pready
);
  localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_SCAN = 3'd1;
  localparam logic [2:0] ST_LAST = 3'd2;
  localparam logic [2:0] ST_DEC  = 3'd3;
  localparam logic [2:0] ST_OUT  = 3'd4;

  typedef struct packed {
    logic [31:0] ip;
    logic [47:0] mac;
    logic [1:0]  mode;
    logic [31:0] stamp;
    logic [15:0] held;
  } ent_t;

  are_pkg::cfg_t cfg;

  are_cfg u_cfg (
    .clk(clk), .rst(rst), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready), .cfg(cfg)
  );

  ent_t mem [TABLE_ENTRIES];
  ent_t rd;
  logic [TABLE_ENTRIES-1:0] vld;

  logic [2:0]  state;
  are_pkg::in_word_t cur;
  logic [IW:0] rptr;
  logic [IW-1:0] cidx;
  logic        found, have_free;
  logic [IW-1:0] fidx, freeidx;
  ent_t        fent;
  logic [31:0] now_ticks;
  logic        wr_en;
  logic [IW-1:0] wr_idx;
  ent_t        wr_ent;
  are_pkg::out_word_t res;
  are_pkg::out_word_t result;

  logic        rd_en;
  logic [IW-1:0] rd_idx;
  assign rd_idx = rptr[IW-1:0];

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_idx] <= wr_ent;
    if (rd_en) rd <= mem[rd_idx];
  end

  assign in_ready = (state == ST_IDLE);
  assign rd_en = (state == ST_SCAN);

  logic [31:0] age, limit;
  logic        expd;
  always_comb begin
    age = now_ticks - fent.stamp;
    unique case (fent.mode)
      are_pkg::MODE_ALIVE: limit = cfg.alive_timeout;
      are_pkg::MODE_WAIT:  limit = cfg.wait_timeout;
      default:             limit = cfg.dead_timeout;
    endcase
    expd = age >= limit;
  end

  logic [31:0] key;
  logic        own_tip;
  assign key = (cur.kind == are_pkg::KIND_LOOKUP) ? cur.target_ip : cur.sender_ip;
  assign own_tip = cur.target_ip == cfg.own_ip;

  always_comb begin
    wr_en  = 1'b0;
    wr_idx = fidx;
    wr_ent = fent;
    res    = '0;
    if (cur.kind == are_pkg::KIND_LOOKUP) begin
      if (!found) begin
        if (!have_free) begin
          res.dropped_valid  = 1'b1;
          res.dropped_handle = cur.packet_handle;
        end else begin
          wr_en = 1'b1;
          wr_idx = freeidx;
          wr_ent = '{cur.target_ip, 48'd0, are_pkg::MODE_WAIT, now_ticks,
                     cur.packet_handle};
          res.action = are_pkg::ACT_REQUEST;
          res.out_ip = cur.target_ip;
          res.out_mac = are_pkg::MAC_BCAST;
        end
      end else if (expd) begin
        wr_en = 1'b1;
        wr_ent.stamp = now_ticks;
        if (fent.mode == are_pkg::MODE_WAIT) begin
          wr_ent.mode = are_pkg::MODE_DEAD;
          res.dropped_valid  = 1'b1;
          res.dropped_handle = cur.packet_handle;
        end else begin
          wr_ent.mode = are_pkg::MODE_WAIT;
          wr_ent.held = cur.packet_handle;
          res.action = are_pkg::ACT_REQUEST;
          res.out_ip = cur.target_ip;
          res.out_mac = are_pkg::MAC_BCAST;
        end
      end else if (fent.mode == are_pkg::MODE_ALIVE) begin
        res.action = are_pkg::ACT_SEND;
        res.out_ip = cur.target_ip;
        res.out_mac = fent.mac;
        res.out_handle = cur.packet_handle;
      end else if (fent.mode == are_pkg::MODE_WAIT) begin
        wr_en = 1'b1;
        wr_ent.held = cur.packet_handle;
        res.dropped_valid  = 1'b1;
        res.dropped_handle = fent.held;
      end else begin
        res.dropped_valid  = 1'b1;
        res.dropped_handle = cur.packet_handle;
      end
    end else if (cur.arp_op == are_pkg::OP_REQUEST && own_tip) begin
      res.action = are_pkg::ACT_REPLY;
      res.out_ip = cur.sender_ip;
      res.out_mac = cur.sender_mac;
    end else if (cur.arp_op == are_pkg::OP_REPLY && own_tip &&
                 cur.target_mac == cfg.own_mac && found &&
                 fent.mode == are_pkg::MODE_WAIT) begin
      wr_en = 1'b1;
      wr_ent.mode = are_pkg::MODE_ALIVE;
      wr_ent.mac = cur.sender_mac;
      wr_ent.stamp = now_ticks;
      res.action = are_pkg::ACT_RELEASE;
      res.out_ip = cur.sender_ip;
      res.out_mac = cur.sender_mac;
      res.out_handle = fent.held;
    end
    if (state != ST_DEC) wr_en = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      vld <= '0;
      now_ticks <= '0;
      out_valid <= 1'b0;
      rptr <= '0;
      found <= 1'b0;
      have_free <= 1'b0;
    end else begin
      if (state == ST_OUT) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (in_valid && in_ready) begin
            cur <= in_data;
            unique case (in_data.kind)
              are_pkg::KIND_TICK: begin
                now_ticks <= now_ticks + 32'd1;
                result <= '0;
                state <= ST_OUT;
              end
              are_pkg::KIND_FLUSH: begin
                vld <= '0;
                result <= '0;
                state <= ST_OUT;
              end
              default: begin
                rptr <= '0;
                found <= 1'b0;
                have_free <= 1'b0;
                state <= ST_SCAN;
              end
            endcase
          end
        end
        ST_SCAN: begin
          cidx <= rd_idx;
          rptr <= rptr + 1'b1;
          if (rptr == (IW+1)'(TABLE_ENTRIES - 1)) state <= ST_LAST;
          if (rptr != '0) begin
            if (!found && vld[cidx] && rd.ip == key) begin
              found <= 1'b1; fidx <= cidx; fent <= rd;
            end
            if (!have_free && !vld[cidx]) begin
              have_free <= 1'b1; freeidx <= cidx;
            end
          end
        end
        ST_LAST: begin
          if (!found && vld[cidx] && rd.ip == key) begin
            found <= 1'b1; fidx <= cidx; fent <= rd;
          end
          if (!have_free && !vld[cidx]) begin
            have_free <= 1'b1; freeidx <= cidx;
          end
          state <= ST_DEC;
        end
        ST_DEC: begin
          result <= res;
          if (wr_en) vld[wr_idx] <= 1'b1;
          state <= ST_OUT;
        end
        ST_OUT: begin
          if (!out_valid || out_ready) begin
            out_data <= result;
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (state != ST_IDLE) |-> !in_ready) else $error("accept while busy");
  a_out_after_out: assert property (@(posedge clk) disable iff (rst)
    (state == ST_OUT) |=> out_valid) else $error("result not presented");
  a_dec_then_out: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DEC) |=> (state == ST_OUT)) else $error("sequence broken");
  a_tick_count: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && in_data.kind == are_pkg::KIND_TICK) |=>
    (now_ticks == $past(now_ticks) + 32'd1)) else $error("tick lost");
endmodule

// File: dv/tb_arp_resolution_engine.sv
// Testbench for arp_resolution_engine: directed table, a full-table fill, then random words,
// checked against an in-bench model of the ARP entry table and timers.
// Depends on are_pkg and the engine RTL.
`timescale 1ns / 1ps
module tb_arp_resolution_engine;

  localparam int N_ENTRIES = 16;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int HOLD_CYCLES = 400;
  localparam int HOLD_PHASE = 4;
  localparam logic [1:0] OP_OTHER_LO = 2'd0;
  localparam logic [1:0] OP_OTHER_HI = 2'd3;

  logic clk;
  logic rst;
  logic in_valid;
  logic in_ready;
  are_pkg::in_word_t in_data;
  logic out_valid;
  logic out_ready;
  are_pkg::out_word_t out_data;
  logic psel;
  logic penable;
  logic pwrite;
  logic [5:0] paddr;
  logic [63:0] pwdata;
  logic [63:0] prdata;
  logic pready;

  arp_resolution_engine dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // model state
  are_pkg::cfg_t cfg;
  logic tbl_valid [N_ENTRIES];
  logic [31:0] tbl_ip [N_ENTRIES];
  logic [47:0] tbl_mac [N_ENTRIES];
  logic [1:0] tbl_mode [N_ENTRIES];
  logic [31:0] tbl_stamp [N_ENTRIES];
  logic [15:0] tbl_held [N_ENTRIES];
  logic [31:0] ticks;

  are_pkg::out_word_t expected_q[$];
  int errors = 0;
  int row_errors;
  int idle_cycles;
  int send_idle_pct;
  int recv_stall_pct;
  int phase;
  int hold_cnt;
  logic hold_done;
  logic finished;

  // address pool so lookups and replies hit
  logic [31:0] ip_pool [24];

  typedef struct {
    are_pkg::in_word_t w;
    logic fixed;
    are_pkg::out_word_t res;
  } row_t;

  row_t rows[$];

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic are_pkg::out_word_t mk(logic [2:0] act, logic [31:0] ip,
                                            logic [47:0] mac, logic [15:0] h,
                                            logic dv, logic [15:0] dh);
    are_pkg::out_word_t r;
    r.action = act;
    r.out_ip = ip;
    r.out_mac = mac;
    r.out_handle = h;
    r.dropped_valid = dv;
    r.dropped_handle = dh;
    return r;
  endfunction

  function automatic int match_entry(logic [31:0] ip);
    for (int i = 0; i < N_ENTRIES; i++)
      if (tbl_valid[i] && tbl_ip[i] == ip) return i;
    return -1;
  endfunction

  function automatic logic entry_expired(int i);
    logic [31:0] age;
    logic [31:0] lim;
    age = ticks - tbl_stamp[i];
    if (tbl_mode[i] == are_pkg::MODE_ALIVE) lim = cfg.alive_timeout;
    else if (tbl_mode[i] == are_pkg::MODE_WAIT) lim = cfg.wait_timeout;
    else lim = cfg.dead_timeout;
    return age >= lim;
  endfunction

  function automatic are_pkg::out_word_t resolve_word(are_pkg::in_word_t w);
    are_pkg::out_word_t r;
    int i;
    logic [15:0] old;
    r = mk(are_pkg::ACT_NONE, '0, '0, '0, 1'b0, '0);
    case (w.kind)
      are_pkg::KIND_TICK: ticks = ticks + 32'd1;
      are_pkg::KIND_FLUSH: for (int k = 0; k < N_ENTRIES; k++) tbl_valid[k] = 1'b0;
      are_pkg::KIND_LOOKUP: begin
        i = match_entry(w.target_ip);
        if (i < 0) begin
          for (int k = N_ENTRIES - 1; k >= 0; k--) if (!tbl_valid[k]) i = k;
          if (i < 0) begin
            r = mk(are_pkg::ACT_NONE, '0, '0, '0, 1'b1, w.packet_handle);
          end else begin
            tbl_valid[i] = 1'b1;
            tbl_ip[i] = w.target_ip;
            tbl_mac[i] = '0;
            tbl_mode[i] = are_pkg::MODE_WAIT;
            tbl_held[i] = w.packet_handle;
            tbl_stamp[i] = ticks;
            r = mk(are_pkg::ACT_REQUEST, w.target_ip, are_pkg::MAC_BCAST, '0, 1'b0, '0);
          end
        end else if (entry_expired(i)) begin
          if (tbl_mode[i] == are_pkg::MODE_WAIT) begin
            tbl_mode[i] = are_pkg::MODE_DEAD;
            tbl_stamp[i] = ticks;
            r = mk(are_pkg::ACT_NONE, '0, '0, '0, 1'b1, w.packet_handle);
          end else begin
            tbl_mode[i] = are_pkg::MODE_WAIT;
            tbl_held[i] = w.packet_handle;
            tbl_stamp[i] = ticks;
            r = mk(are_pkg::ACT_REQUEST, w.target_ip, are_pkg::MAC_BCAST, '0, 1'b0, '0);
          end
        end else if (tbl_mode[i] == are_pkg::MODE_ALIVE) begin
          r = mk(are_pkg::ACT_SEND, w.target_ip, tbl_mac[i], w.packet_handle, 1'b0, '0);
        end else if (tbl_mode[i] == are_pkg::MODE_WAIT) begin
          old = tbl_held[i];
          tbl_held[i] = w.packet_handle;
          r = mk(are_pkg::ACT_NONE, '0, '0, '0, 1'b1, old);
        end else begin
          r = mk(are_pkg::ACT_NONE, '0, '0, '0, 1'b1, w.packet_handle);
        end
      end
      default: begin
        if (w.arp_op == are_pkg::OP_REQUEST && w.target_ip == cfg.own_ip) begin
          r = mk(are_pkg::ACT_REPLY, w.sender_ip, w.sender_mac, '0, 1'b0, '0);
        end else if (w.arp_op == are_pkg::OP_REPLY && w.target_ip == cfg.own_ip &&
                     w.target_mac == cfg.own_mac) begin
          i = match_entry(w.sender_ip);
          if (i >= 0 && tbl_mode[i] == are_pkg::MODE_WAIT) begin
            tbl_mode[i] = are_pkg::MODE_ALIVE;
            tbl_mac[i] = w.sender_mac;
            tbl_stamp[i] = ticks;
            r = mk(are_pkg::ACT_RELEASE, w.sender_ip, w.sender_mac, tbl_held[i],
                   1'b0, '0);
          end
        end
      end
    endcase
    return r;
  endfunction

  function automatic are_pkg::in_word_t word_of(logic [1:0] k, logic [31:0] tip,
                                                logic [15:0] h, logic [1:0] op,
                                                logic [31:0] sip, logic [47:0] smac,
                                                logic [47:0] tmac);
    are_pkg::in_word_t w;
    w.kind = k;
    w.target_ip = tip;
    w.packet_handle = h;
    w.arp_op = op;
    w.sender_ip = sip;
    w.sender_mac = smac;
    w.target_mac = tmac;
    return w;
  endfunction

  function automatic logic [47:0] rand_mac();
    return {16'($urandom_range(0, 65535)), $urandom()};
  endfunction

  function automatic are_pkg::in_word_t random_word();
    int sel;
    logic [31:0] ip;
    logic [31:0] tip;
    logic [15:0] h;
    logic [1:0] op;
    logic [31:0] sip;
    sel = $urandom_range(0, 99);
    ip = ($urandom_range(0, 9) == 0) ? $urandom() : ip_pool[$urandom_range(0, 23)];
    tip = $urandom();
    h = 16'($urandom());
    op = 2'($urandom());
    sip = $urandom();
    if (sel < 25)
      return word_of(are_pkg::KIND_TICK, tip, h, op, sip, rand_mac(), rand_mac());
    if (sel < 60)
      return word_of(are_pkg::KIND_LOOKUP, ip, h, op, sip, rand_mac(), rand_mac());
    if (sel < 75)
      return word_of(are_pkg::KIND_ARP, ($urandom_range(0, 4) == 0) ? tip : cfg.own_ip,
                     h, are_pkg::OP_REQUEST, sip, rand_mac(), rand_mac());
    if (sel < 92)
      return word_of(are_pkg::KIND_ARP, ($urandom_range(0, 9) == 0) ? tip : cfg.own_ip,
                     h, are_pkg::OP_REPLY, ip, rand_mac(),
                     ($urandom_range(0, 9) == 0) ? rand_mac() : cfg.own_mac);
    if (sel < 97)
      return word_of(are_pkg::KIND_ARP, cfg.own_ip, h,
                     ($urandom_range(0, 1) == 0) ? OP_OTHER_LO : OP_OTHER_HI,
                     sip, rand_mac(), rand_mac());
    return word_of(are_pkg::KIND_FLUSH, tip, h, op, sip, rand_mac(), rand_mac());
  endfunction

  task automatic cfg_write(logic [2:0] idx, logic [63:0] val);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 3'b000};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      are_pkg::REG_OWN_IP: cfg.own_ip = val[31:0];
      are_pkg::REG_OWN_MAC: cfg.own_mac = val[47:0];
      are_pkg::REG_ALIVE: cfg.alive_timeout = val[31:0];
      are_pkg::REG_DEAD: cfg.dead_timeout = val[31:0];
      default: cfg.wait_timeout = val[31:0];
    endcase
  endtask

  task automatic add_row(are_pkg::in_word_t w, logic fixed, are_pkg::out_word_t res);
    row_t r;
    r.w = w;
    r.fixed = fixed;
    r.res = res;
    rows.insert(rows.size(), r);
  endtask

  task automatic send_word(are_pkg::in_word_t w, logic check_fixed,
                           are_pkg::out_word_t fixed);
    are_pkg::out_word_t p;
    while (send_idle_pct > 0 && $urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    p = resolve_word(w);
    if (check_fixed && p !== fixed) begin
      $display("%0t directed row expected %h predicted %h", $time, fixed, p);
      row_errors++;
    end
    expected_q.insert(expected_q.size(), check_fixed ? fixed : p);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  // receiver, with one long hold-off during the pressure phase
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      hold_cnt <= 0;
      hold_done <= 1'b0;
    end else if (hold_cnt > 0) begin
      out_ready <= 1'b0;
      hold_cnt <= hold_cnt - 1;
    end else if (phase == HOLD_PHASE && !hold_done) begin
      out_ready <= 1'b0;
      hold_cnt <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else begin
      out_ready <= !(recv_stall_pct > 0 && $urandom_range(0, 99) < recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (expected_q.size() == 0) begin
        $display("%0t unexpected word expected none actual %h", $time, out_data);
        errors++;
      end else begin
        are_pkg::out_word_t e;
        e = expected_q.pop_front();
        if (out_data.action !== e.action || out_data.out_ip !== e.out_ip ||
            out_data.out_mac !== e.out_mac || out_data.out_handle !== e.out_handle ||
            out_data.dropped_valid !== e.dropped_valid ||
            out_data.dropped_handle !== e.dropped_handle) begin
          $display("%0t mismatch expected %h actual %h", $time, e, out_data);
          errors++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (!finished) begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  initial begin
    row_errors = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    phase = -1;
    finished = 1'b0;
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    cfg.own_ip = '0;
    cfg.own_mac = '0;
    cfg.alive_timeout = 32'd1200;
    cfg.dead_timeout = 32'd1000;
    cfg.wait_timeout = 32'd10;
    for (int i = 0; i < N_ENTRIES; i++) tbl_valid[i] = 1'b0;
    ticks = '0;
    for (int i = 0; i < 24; i++) ip_pool[i] = (i == 0) ? 32'hFFFF_FFFF : $urandom();
    ip_pool[1] = 32'h0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: reset config, then extremes
    add_row(word_of(are_pkg::KIND_ARP, '0, '0, are_pkg::OP_REQUEST, 32'hFFFF_FFFF,
                    are_pkg::MAC_BCAST, '0), 1'b1,
            mk(are_pkg::ACT_REPLY, 32'hFFFF_FFFF, are_pkg::MAC_BCAST, '0, 1'b0, '0));
    add_row(word_of(are_pkg::KIND_LOOKUP, 32'hFFFF_FFFF, 16'hFFFF, '0, '0, '0, '0), 1'b1,
            mk(are_pkg::ACT_REQUEST, 32'hFFFF_FFFF, are_pkg::MAC_BCAST, '0, 1'b0, '0));
    add_row(word_of(are_pkg::KIND_LOOKUP, 32'hFFFF_FFFF, 16'h0000, '0, '0, '0, '0), 1'b1,
            mk(are_pkg::ACT_NONE, '0, '0, '0, 1'b1, 16'hFFFF));
    add_row(word_of(are_pkg::KIND_ARP, '0, '0, are_pkg::OP_REPLY, 32'hFFFF_FFFF,
                    48'h1234_5678_9ABC, '0), 1'b1,
            mk(are_pkg::ACT_RELEASE, 32'hFFFF_FFFF, 48'h1234_5678_9ABC, '0, 1'b0, '0));
    add_row(word_of(are_pkg::KIND_LOOKUP, 32'hFFFF_FFFF, 16'h8001, '0, '0, '0, '0), 1'b1,
            mk(are_pkg::ACT_SEND, 32'hFFFF_FFFF, 48'h1234_5678_9ABC, 16'h8001, 1'b0, '0));
    add_row(word_of(are_pkg::KIND_ARP, '0, '0, are_pkg::OP_REPLY, 32'h0A00_0001,
                    48'h1, '0), 1'b1,
            mk(are_pkg::ACT_NONE, '0, '0, '0, 1'b0, '0));
    add_row(word_of(are_pkg::KIND_ARP, '0, '0, OP_OTHER_HI, '0, '0, '0), 1'b1,
            mk(are_pkg::ACT_NONE, '0, '0, '0, 1'b0, '0));
    add_row(word_of(are_pkg::KIND_ARP, '0, '0, OP_OTHER_LO, '0, '0, '0), 1'b1,
            mk(are_pkg::ACT_NONE, '0, '0, '0, 1'b0, '0));
    add_row(word_of(are_pkg::KIND_LOOKUP, '0, 16'h1111, '0, '0, '0, '0), 1'b0, '0);
    for (int k = 0; k < 11; k++)
      add_row(word_of(are_pkg::KIND_TICK, '0, '0, '0, '0, '0, '0), 1'b0, '0);
    // expired waiting entry goes dead, then dead entry drops
    add_row(word_of(are_pkg::KIND_LOOKUP, '0, 16'h2222, '0, '0, '0, '0), 1'b0, '0);
    add_row(word_of(are_pkg::KIND_LOOKUP, '0, 16'h3333, '0, '0, '0, '0), 1'b0, '0);
    add_row(word_of(are_pkg::KIND_FLUSH, 32'hFFFF_FFFF, 16'hFFFF, OP_OTHER_HI,
                    32'hFFFF_FFFF, are_pkg::MAC_BCAST, are_pkg::MAC_BCAST), 1'b1,
            mk(are_pkg::ACT_NONE, '0, '0, '0, 1'b0, '0));
    foreach (rows[i]) send_word(rows[i].w, rows[i].fixed, rows[i].res);
    drain();

    // full table
    for (int k = 0; k < N_ENTRIES + 2; k++)
      send_word(word_of(are_pkg::KIND_LOOKUP, 32'h0B00_0000 + 32'(k), 16'(k),
                        '0, '0, '0, '0), 1'b0, '0);
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin
          cfg_write(are_pkg::REG_OWN_IP, 64'h0000_0000_FFFF_FFFF);
          cfg_write(are_pkg::REG_OWN_MAC, 64'(are_pkg::MAC_BCAST));
          cfg_write(are_pkg::REG_ALIVE, 64'h0000_0000_FFFF_FFFF);
          cfg_write(are_pkg::REG_DEAD, 64'h0000_0000_FFFF_FFFF);
          cfg_write(are_pkg::REG_WAIT, 64'h0000_0000_FFFF_FFFF);
          send_idle_pct = 0; recv_stall_pct = 0;
        end
        1: begin
          cfg_write(are_pkg::REG_OWN_IP, 64'($urandom()));
          cfg_write(are_pkg::REG_OWN_MAC, 64'(rand_mac()));
          cfg_write(are_pkg::REG_ALIVE, 64'd1);
          cfg_write(are_pkg::REG_DEAD, 64'd1);
          cfg_write(are_pkg::REG_WAIT, 64'd1);
          send_idle_pct = 67; recv_stall_pct = 0;
        end
        2: begin
          cfg_write(are_pkg::REG_OWN_IP, 64'd0);
          cfg_write(are_pkg::REG_OWN_MAC, 64'd0);
          cfg_write(are_pkg::REG_ALIVE, 64'd40);
          cfg_write(are_pkg::REG_DEAD, 64'd20);
          cfg_write(are_pkg::REG_WAIT, 64'd6);
          send_idle_pct = 0; recv_stall_pct = 67;
        end
        3: begin
          cfg_write(are_pkg::REG_OWN_IP, 64'($urandom()));
          cfg_write(are_pkg::REG_ALIVE, 64'($urandom_range(10, 60)));
          cfg_write(are_pkg::REG_WAIT, 64'($urandom_range(2, 12)));
          send_idle_pct = 24; recv_stall_pct = 24;
        end
        4: begin
          send_idle_pct = 0; recv_stall_pct = 0;
        end
        default: begin
          cfg_write(are_pkg::REG_OWN_MAC, 64'(rand_mac()));
          cfg_write(are_pkg::REG_DEAD, 64'd5);
          send_idle_pct = int'($urandom_range(0, 30));
          recv_stall_pct = int'($urandom_range(0, 30));
        end
      endcase
      phase = ph;
      for (int n = 0; n < 140; n++) send_word(random_word(), 1'b0, '0);
      drain();
    end

    finished = 1'b1;
    if (errors == 0 && row_errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
